// ===== design/pcst_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcst_pkg
// shared types and constants for the per-id call statistics table
// ----------------------------------------------------------------------------
package pcst_pkg;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOT_DONE = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic [29:0] NS_PER_SEC = 30'd1000000000;

  // classified event handed from front to back
  typedef struct packed {
    logic [15:0] call_id;
    logic        done;
    logic        err;
    logic [63:0] ns;
  } evt_t;

endpackage
`default_nettype wire

// ===== design/per_id_call_statistics_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// per_id_call_statistics_table
// per-identifier call counters with global totals
// ----------------------------------------------------------------------------
// One result per event. The front computes elapsed time over registered stages
// s1 and s2 and queues events; the back scans stored keys one row at a time
// (SCAN then CHECK), then does a read-modify-write of that row's counters, and
// takes no new event until the result of the last one is accepted.
module per_id_call_statistics_table #(
  parameter int TABLE_ROWS = 64
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire [15:0]  call_id,
  input  wire         completed,
  input  wire [11:0]  error_code,
  input  wire [31:0]  entry_seconds,
  input  wire [29:0]  entry_nanos,
  input  wire [31:0]  exit_seconds,
  input  wire [29:0]  exit_nanos,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [1:0]  status,
  output logic [5:0]  row_index,
  output logic [63:0] row_calls,
  output logic [63:0] row_errors,
  output logic [63:0] row_time,
  output logic [63:0] all_calls,
  output logic [63:0] all_errors,
  output logic [63:0] all_time
);
  logic           q_valid;
  logic           q_ready;
  pcst_pkg::evt_t q_data;

  pcst_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .call_id(call_id), .completed(completed), .error_code(error_code),
    .entry_seconds(entry_seconds), .entry_nanos(entry_nanos),
    .exit_seconds(exit_seconds), .exit_nanos(exit_nanos),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
  );

  pcst_back #(.TABLE_ROWS(TABLE_ROWS)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .row_index(row_index), .row_calls(row_calls), .row_errors(row_errors),
    .row_time(row_time), .all_calls(all_calls), .all_errors(all_errors),
    .all_time(all_time)
  );
endmodule
`default_nettype wire

// ===== design/pcst_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcst_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module pcst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire                                          clk,
  input  wire                                          we,
  input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  addr,
  input  wire [WIDTH-1:0]                              wdata,
  output logic [WIDTH-1:0]                             rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== design/pcst_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcst_front
// computes elapsed time over two stages and pushes events into a queue
// ----------------------------------------------------------------------------
module pcst_front (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire [15:0]          call_id,
  input  wire                 completed,
  input  wire [11:0]          error_code,
  input  wire [31:0]          entry_seconds,
  input  wire [29:0]          entry_nanos,
  input  wire [31:0]          exit_seconds,
  input  wire [29:0]          exit_nanos,
  output logic                q_valid,
  input  wire                 q_ready,
  output pcst_pkg::evt_t      q_data
);
  // stage 1 registers
  logic               s1_valid;
  logic [15:0]        s1_id;
  logic               s1_done;
  logic               s1_err;
  logic signed [32:0] s1_ds;
  logic signed [30:0] s1_dn;
  // stage 2 product
  logic               s2_valid;
  logic [15:0]        s2_id;
  logic               s2_done;
  logic               s2_err;
  logic signed [63:0] s2_prod;
  logic signed [30:0] s2_dn;
  logic signed [63:0] span;

  // two-entry queue
  pcst_pkg::evt_t     qmem [2];
  logic               wptr;
  logic               rptr;
  logic [1:0]         count;
  logic               push;
  logic               pop;
  logic [1:0]         inflight;

  assign inflight = {1'b0, s1_valid} + {1'b0, s2_valid};
  // admit only when the queue has room for everything in flight
  assign in_ready = (count + inflight) < 2'd2 && !(s1_valid && s2_valid);
  assign span     = s2_prod + 64'(s2_dn);
  assign push     = s2_valid;
  assign pop      = q_valid && q_ready;
  assign q_valid  = count != 2'd0;
  assign q_data   = qmem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      wptr     <= 1'b0;
      rptr     <= 1'b0;
      count    <= 2'd0;
    end else begin
      s1_valid <= in_valid && in_ready;
      s2_valid <= s1_valid;
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
    s1_id   <= call_id;
    s1_done <= completed;
    s1_err  <= error_code != 12'd0;
    s1_ds   <= $signed({1'b0, exit_seconds}) - $signed({1'b0, entry_seconds});
    s1_dn   <= $signed({1'b0, exit_nanos}) - $signed({1'b0, entry_nanos});
    s2_id   <= s1_id;
    s2_done <= s1_done;
    s2_err  <= s1_err;
    s2_dn   <= s1_dn;
    s2_prod <= 64'(s1_ds * $signed({1'b0, pcst_pkg::NS_PER_SEC}));
    if (push) begin
      qmem[wptr].call_id <= s2_id;
      qmem[wptr].done    <= s2_done;
      qmem[wptr].err     <= s2_err;
      qmem[wptr].ns      <= span[63] ? 64'd0 : span;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && count == 2'd2 && !pop))
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && count == 2'd0))
    else $error("queue underflow");
endmodule
`default_nettype wire

// ===== design/pcst_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcst_back
// searches the key table one row at a time and updates counters in ram
// ----------------------------------------------------------------------------
module pcst_back #(
  parameter int TABLE_ROWS = 64
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 q_valid,
  output logic                q_ready,
  input  wire pcst_pkg::evt_t q_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output logic [1:0]          status,
  output logic [5:0]          row_index,
  output logic [63:0]         row_calls,
  output logic [63:0]         row_errors,
  output logic [63:0]         row_time,
  output logic [63:0]         all_calls,
  output logic [63:0]         all_errors,
  output logic [63:0]         all_time
);
  localparam int AW = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
  localparam int CW = $clog2(TABLE_ROWS + 1);

  typedef enum logic [2:0] {IDLE, SCAN, CHECK, READ, UPDATE, RESULT} state_t;
  state_t state;

  pcst_pkg::evt_t ev;
  logic [CW-1:0]  rows_used;
  logic [CW-1:0]  idx;
  logic [AW-1:0]  row;
  logic           found;
  logic [63:0]    tot_calls;
  logic [63:0]    tot_errors;
  logic [63:0]    tot_time;

  logic           key_we;
  logic           cnt_we;
  logic [AW-1:0]  addr;
  logic [15:0]    key_rd;
  logic [191:0]   cnt_rd;
  logic [191:0]   cnt_wd;
  logic [63:0]    rc;
  logic [63:0]    re;
  logic [63:0]    rt;
  logic           row_ovf;

  assign addr = (state == SCAN) ? idx[AW-1:0] : row;
  assign rc   = found ? cnt_rd[191:128] : 64'd0;
  assign re   = found ? cnt_rd[127:64]  : 64'd0;
  assign rt   = found ? cnt_rd[63:0]    : 64'd0;
  assign row_ovf = rc == '1 || rt > ~ev.ns || (ev.err && re == '1);
  assign cnt_wd  = {rc + 64'd1, re + {63'd0, ev.err}, rt + ev.ns};
  assign key_we  = state == READ && !found;
  assign cnt_we  = state == UPDATE && !row_ovf;
  assign q_ready = state == IDLE && !out_valid;

  pcst_ram #(.WIDTH(16), .DEPTH(TABLE_ROWS)) u_key (
    .clk(clk), .we(key_we), .addr(addr), .wdata(ev.call_id), .rdata(key_rd)
  );
  pcst_ram #(.WIDTH(192), .DEPTH(TABLE_ROWS)) u_cnt (
    .clk(clk), .we(cnt_we), .addr(addr), .wdata(cnt_wd), .rdata(cnt_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      out_valid  <= 1'b0;
      rows_used  <= '0;
      tot_calls  <= '0;
      tot_errors <= '0;
      tot_time   <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (q_valid && q_ready) begin
            ev    <= q_data;
            idx   <= '0;
            found <= 1'b0;
            if (!q_data.done) begin
              status <= pcst_pkg::ST_NOT_DONE;
              state  <= RESULT;
            end else if (tot_calls == '1 || tot_time > ~q_data.ns ||
                         (q_data.err && tot_errors == '1)) begin
              status <= pcst_pkg::ST_OVERFLOW;
              state  <= RESULT;
            end else begin
              state <= SCAN;
            end
          end
        end
        SCAN: begin
          // key read issued at idx, compared next cycle
          if (idx >= rows_used) begin
            state <= CHECK;
          end else begin
            state <= CHECK;
            row   <= idx[AW-1:0];
          end
        end
        CHECK: begin
          if (idx < rows_used && key_rd == ev.call_id) begin
            found <= 1'b1;
            state <= READ;
          end else if (idx < rows_used) begin
            idx   <= idx + 1'b1;
            state <= SCAN;
          end else if (rows_used == CW'(TABLE_ROWS)) begin
            status <= pcst_pkg::ST_FULL;
            state  <= RESULT;
          end else begin
            row   <= rows_used[AW-1:0];
            state <= READ;
          end
        end
        READ: begin
          if (!found) begin
            rows_used <= rows_used + 1'b1;
          end
          state <= UPDATE;
        end
        UPDATE: begin
          if (row_ovf) begin
            status <= pcst_pkg::ST_OVERFLOW;
          end else begin
            status     <= pcst_pkg::ST_OK;
            row_index  <= 6'(row);
            row_calls  <= cnt_wd[191:128];
            row_errors <= cnt_wd[127:64];
            row_time   <= cnt_wd[63:0];
            tot_calls  <= tot_calls + 64'd1;
            tot_errors <= tot_errors + {63'd0, ev.err};
            tot_time   <= tot_time + ev.ns;
          end
          state <= RESULT;
        end
        RESULT: begin
          if (status != pcst_pkg::ST_OK) begin
            row_index  <= '0;
            row_calls  <= '0;
            row_errors <= '0;
            row_time   <= '0;
          end
          all_calls  <= tot_calls;
          all_errors <= tot_errors;
          all_time   <= tot_time;
          out_valid  <= 1'b1;
          state      <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_rows_range: assert property (@(posedge clk) disable iff (rst)
    rows_used <= CW'(TABLE_ROWS))
    else $error("rows_used past table size");
  a_no_full_append: assert property (@(posedge clk) disable iff (rst)
    !(key_we && rows_used >= CW'(TABLE_ROWS)))
    else $error("append to full table");
  a_cnt_write: assert property (@(posedge clk) disable iff (rst)
    !(cnt_we && state != UPDATE))
    else $error("stray counter write");
endmodule
`default_nettype wire

// ===== test/per_id_call_statistics_table_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_id_call_statistics_table_tb
// drives call events with random bursts and output stalls, predicts each
// status, row and total result, and compares every field in order
// ----------------------------------------------------------------------------
module per_id_call_statistics_table_tb;

  localparam int ROWS = 64;
  localparam longint unsigned NS_SEC = 64'd1000000000;
  localparam longint MAX_CYCLES = 1000000;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  row_index;
    logic [63:0] row_calls;
    logic [63:0] row_errors;
    logic [63:0] row_time;
    logic [63:0] all_calls;
    logic [63:0] all_errors;
    logic [63:0] all_time;
  } stat_res_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] call_id;
  logic        completed;
  logic [11:0] error_code;
  logic [31:0] entry_seconds;
  logic [29:0] entry_nanos;
  logic [31:0] exit_seconds;
  logic [29:0] exit_nanos;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  status;
  logic [5:0]  row_index;
  logic [63:0] row_calls;
  logic [63:0] row_errors;
  logic [63:0] row_time;
  logic [63:0] all_calls;
  logic [63:0] all_errors;
  logic [63:0] all_time;

  int mismatches = 0;
  longint cycles = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    mismatches++;
  endtask

  class stats_scoreboard;
    logic [15:0] keys[ROWS];
    logic [63:0] calls_tab[ROWS];
    logic [63:0] errs_tab[ROWS];
    logic [63:0] time_tab[ROWS];
    int used;
    logic [63:0] tot_calls, tot_errs, tot_time;
    stat_res_t pending[$];

    function new();
      used = 0;
      tot_calls = 0;
      tot_errs = 0;
      tot_time = 0;
    endfunction

    function logic [63:0] elapsed(logic [31:0] s_in, logic [29:0] n_in,
                                  logic [31:0] s_out, logic [29:0] n_out);
      longint t;
      t = (longint'(s_out) - longint'(s_in)) * longint'(NS_SEC)
          + (longint'(n_out) - longint'(n_in));
      return (t < 0) ? 64'd0 : 64'(t);
    endfunction

    function void note_event(logic [15:0] id, logic done, logic [11:0] ec,
                             logic [31:0] es, logic [29:0] en,
                             logic [31:0] xs, logic [29:0] xn);
      stat_res_t r;
      logic [63:0] ns;
      logic err, found;
      logic [1:0] st;
      int row;
      ns = elapsed(es, en, xs, xn);
      err = (ec != 0);
      found = 0;
      row = 0;
      st = pcst_pkg::ST_OK;
      r = '0;
      if (!done) st = pcst_pkg::ST_NOT_DONE;
      else if (tot_calls == '1 || tot_time > ('1 - ns) || (err && tot_errs == '1))
        st = pcst_pkg::ST_OVERFLOW;
      else begin
        for (int i = 0; i < used; i++)
          if (!found && keys[i] == id) begin
            row = i;
            found = 1;
          end
        if (!found) begin
          if (used >= ROWS) st = pcst_pkg::ST_FULL;
          else row = used;
        end
        if (st == pcst_pkg::ST_OK && found && (calls_tab[row] == '1 ||
            time_tab[row] > ('1 - ns) || (err && errs_tab[row] == '1)))
          st = pcst_pkg::ST_OVERFLOW;
      end
      if (st == pcst_pkg::ST_OK) begin
        if (!found) begin
          keys[row] = id;
          calls_tab[row] = 0;
          errs_tab[row] = 0;
          time_tab[row] = 0;
          used++;
        end
        calls_tab[row] += 1;
        errs_tab[row] += err;
        time_tab[row] += ns;
        tot_calls += 1;
        tot_errs += err;
        tot_time += ns;
        r.row_index = row[5:0];
        r.row_calls = calls_tab[row];
        r.row_errors = errs_tab[row];
        r.row_time = time_tab[row];
      end
      r.status = st;
      r.all_calls = tot_calls;
      r.all_errors = tot_errs;
      r.all_time = tot_time;
      pending.push_back(r);
    endfunction

    task check_result(stat_res_t got);
      stat_res_t w;
      if (pending.size() == 0) begin
        report("unexpected result", 64'(got.status), 0);
        return;
      end
      w = pending.pop_front();
      if (got.status != w.status) report("status", 64'(got.status), 64'(w.status));
      if (got.row_index != w.row_index) report("row_index", 64'(got.row_index), 64'(w.row_index));
      if (got.row_calls != w.row_calls) report("row_calls", got.row_calls, w.row_calls);
      if (got.row_errors != w.row_errors) report("row_errors", got.row_errors, w.row_errors);
      if (got.row_time != w.row_time) report("row_time", got.row_time, w.row_time);
      if (got.all_calls != w.all_calls) report("all_calls", got.all_calls, w.all_calls);
      if (got.all_errors != w.all_errors) report("all_errors", got.all_errors, w.all_errors);
      if (got.all_time != w.all_time) report("all_time", got.all_time, w.all_time);
    endtask
  endclass

  stats_scoreboard sb;

  per_id_call_statistics_table #(.TABLE_ROWS(ROWS)) i_dut (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("timeout");
      $display("Mismatches found");
      $finish;
    end
  end

  // monitor sees outputs before the edge updates them
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result('{status, row_index, row_calls, row_errors, row_time,
                        all_calls, all_errors, all_time});
    if (!rst && in_valid && in_ready)
      sb.note_event(call_id, completed, error_code, entry_seconds, entry_nanos,
                    exit_seconds, exit_nanos);
  end

  // receiver stalls in its own pattern: phases of steady ready and of random ready
  initial begin
    int mode;
    out_ready = 0;
    @(posedge clk iff !rst);
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(5, 60)) begin
        @(posedge clk);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  int burst_left = 0;

  task automatic send_event(input logic [15:0] id, input logic done, input logic [11:0] ec,
                            input logic [31:0] es, input logic [29:0] en,
                            input logic [31:0] xs, input logic [29:0] xn);
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 15);
    end
    burst_left--;
    in_valid <= 1'b1;
    call_id <= id;
    completed <= done;
    error_code <= ec;
    entry_seconds <= es;
    entry_nanos <= en;
    exit_seconds <= xs;
    exit_nanos <= xn;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // stays high when the next transaction follows immediately
    if (burst_left == 0) in_valid <= 1'b0;
  endtask

  task automatic random_event(input logic [15:0] id);
    logic [31:0] es;
    logic [29:0] en, xn;
    es = $urandom;
    en = $urandom_range(0, 999999999);
    xn = $urandom_range(0, 999999999);
    case ($urandom_range(0, 9))
      0: send_event(id, 1'b0, 12'($urandom), es, en, $urandom, xn);
      1: send_event(id, 1'b1, 12'($urandom), $urandom, 30'($urandom), $urandom, 30'($urandom));
      2: send_event(id, 1'b1, 12'($urandom), es, en, es - $urandom_range(0, 3), xn);
      default: send_event(id, 1'b1, ($urandom_range(0, 2) == 0) ? 12'($urandom) : 12'd0,
                          es, en, es + $urandom_range(0, 20), xn);
    endcase
  endtask

  initial begin
    sb = new();
    rst = 1;
    in_valid = 0;
    call_id = 0;
    completed = 0;
    error_code = 0;
    entry_seconds = 0;
    entry_nanos = 0;
    exit_seconds = 0;
    exit_nanos = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: field extremes, borrow, negative span, not completed, repeats
    send_event(16'h0000, 1'b1, 12'd0, 32'd0, 30'd0, 32'd0, 30'd0);
    send_event(16'hffff, 1'b1, 12'hfff, 32'd5, 30'd999999999, 32'd6, 30'd0);
    send_event(16'h0000, 1'b1, 12'd1, 32'd10, 30'd0, 32'd9, 30'd999999999);
    send_event(16'h1234, 1'b0, 12'hfff, 32'd1, 30'd0, 32'd2, 30'd0);
    send_event(16'hffff, 1'b1, 12'd0, 32'd0, 30'd0, 32'hffffffff, 30'd999999999);
    send_event(16'h8000, 1'b1, 12'h800, 32'hffffffff, 30'd999999999, 32'd0, 30'd0);
    send_event(16'h7fff, 1'b1, 12'd0, 32'd3, 30'h3fffffff, 32'd3, 30'h3fffffff);
    send_event(16'h5555, 1'b1, 12'd2, 32'd3, 30'd0, 32'd3, 30'h3fffffff);
    send_event(16'haaaa, 1'b1, 12'd0, 32'd4, 30'h3fffffff, 32'd4, 30'd0);
    send_event(16'h0000, 1'b0, 12'd0, 32'd0, 30'd0, 32'd0, 30'd0);

    // fill the table past full with fresh identifiers, mixing repeats
    for (int i = 0; i < 70; i++) begin
      random_event(16'h0100 + 16'(i));
      if ($urandom_range(0, 2) == 0) random_event(16'h0100 + 16'($urandom_range(0, i)));
    end
    // mostly known identifiers, some new ones that hit the full table
    for (int i = 0; i < 700; i++)
      random_event(($urandom_range(0, 5) == 0) ? 16'($urandom) :
                   16'h0100 + 16'($urandom_range(0, 61)));

    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && sb.pending.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule

// ===== sim.f =====
design/pcst_pkg.sv
design/pcst_ram.sv
design/pcst_front.sv
design/pcst_back.sv
design/per_id_call_statistics_table.sv
test/per_id_call_statistics_table_tb.sv
